@@ src/rrc_pkg.sv @@
// ----------------------------------------------------------------------------
// rrc_pkg
// Types and constants shared by the register read coalescer.
// ----------------------------------------------------------------------------
package rrc_pkg;

  localparam int MaxTags   = 64;
  localparam int IdxW      = $clog2(MaxTags);
  localparam int CntW      = IdxW + 1;
  localparam int KeyW      = 42;
  localparam int PayW      = 23;
  localparam int GkW       = 26;
  localparam int EndW      = 19;

  localparam logic [6:0] MaxGapReset   = 7'd5;
  localparam logic [6:0] MaxBlockReset = 7'd125;

  // configuration register indexes
  localparam logic CfgMaxGap   = 1'b0;
  localparam logic CfgMaxBlock = 1'b1;

  typedef struct packed {
    logic [1:0]  reg_kind;
    logic [23:0] poll_interval;
    logic [15:0] start_address;
    logic [6:0]  reg_count;
    logic [15:0] tag_ident;
    logic        final_tag;
  } tag_t;

  typedef struct packed {
    logic [1:0]  block_kind;
    logic [15:0] block_start;
    logic [6:0]  block_length;
    logic [23:0] block_interval;
    logic [15:0] member_ident;
    logic        block_last;
    logic        plan_last;
  } result_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_RI, ST_RW, ST_RJ, ST_WR, ST_MR, ST_MC, ST_ER, ST_EG, ST_EO
  } state_t;

endpackage

@@ src/register_read_coalescer_core.sv @@
// ----------------------------------------------------------------------------
// register_read_coalescer_core
// Collects tag descriptors, sorts them and coalesces them into read blocks.
// ----------------------------------------------------------------------------
// Tags are taken one request per cycle while loading. The request carrying
// final_tag starts planning; no request is taken until the plan is out. The
// sort is a stable rank count over the tag memory, bound by the single read
// port of the tag memory. The coalescing walk then reads and merges each tag
// in turn (states MR, MC), and the result walk (ER, EG, EO) fetches each
// tag's block through two dependent memory reads. Tags beyond 64 are
// dropped. Configuration is taken at any time and should be changed only
// while idle.
module register_read_coalescer_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rrc_pkg::tag_t     in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rrc_pkg::result_t  out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [6:0]        cfg_data
);

  rrc_pkg::state_t state, state_next;

  logic [6:0] max_gap, max_block;
  logic [rrc_pkg::CntW-1:0] fill_count, n;
  logic [rrc_pkg::IdxW-1:0] nm1, idx, jd, rank, g;
  logic [rrc_pkg::KeyW-1:0] ki;
  logic [rrc_pkg::PayW-1:0] pi;
  logic signed [rrc_pkg::EndW-1:0] cur_end;
  logic [15:0] cur_start;
  logic [rrc_pkg::GkW-1:0] cur_gk;
  logic blk_last;

  // memories
  logic [rrc_pkg::KeyW-1:0] key_mem  [rrc_pkg::MaxTags];
  logic [rrc_pkg::PayW-1:0] pay_mem  [rrc_pkg::MaxTags];
  logic [rrc_pkg::KeyW-1:0] skey_mem [rrc_pkg::MaxTags];
  logic [rrc_pkg::PayW-1:0] spay_mem [rrc_pkg::MaxTags];
  logic [rrc_pkg::IdxW-1:0] gidx_mem [rrc_pkg::MaxTags];
  logic [15:0]              gst_mem  [rrc_pkg::MaxTags];
  logic [6:0]               glen_mem [rrc_pkg::MaxTags];

  logic [rrc_pkg::KeyW-1:0] key_rd, skey_rd;
  logic [rrc_pkg::PayW-1:0] pay_rd, spay_rd;
  logic [rrc_pkg::IdxW-1:0] gidx_rd_a, gidx_rd_b;
  logic [15:0]              gst_rd;
  logic [6:0]               glen_rd;

  logic [rrc_pkg::IdxW-1:0] key_raddr;
  logic in_acc, load_wr, last_all, out_load;

  // rank compare
  logic key_before;

  // coalescing datapath
  logic [15:0] t_addr;
  logic [6:0]  t_cnt;
  logic [rrc_pkg::GkW-1:0] t_gk;
  logic signed [rrc_pkg::EndW-1:0] t_end, new_end, gap, span;
  logic merge;
  logic [rrc_pkg::IdxW-1:0] g_w;

  assign in_acc    = in_valid && in_ready;
  assign load_wr   = in_acc && (fill_count < rrc_pkg::CntW'(rrc_pkg::MaxTags));
  assign cfg_ready = 1'b1;
  assign nm1       = rrc_pkg::IdxW'(n - 1'b1);
  assign last_all  = (idx == nm1);
  assign out_load  = (state == rrc_pkg::ST_EO) && (!out_valid || out_ready);

  assign key_before = (key_rd < ki) || ((key_rd == ki) && (jd < idx));

  assign t_addr  = skey_rd[15:0];
  assign t_gk    = skey_rd[41:16];
  assign t_cnt   = spay_rd[22:16];
  assign t_end   = $signed({3'b000, t_addr}) + $signed({12'd0, t_cnt})
                   - 19'sd1;
  assign new_end = (t_end > cur_end) ? t_end : cur_end;
  assign gap     = $signed({3'b000, t_addr}) - cur_end - 19'sd1;
  assign span    = new_end - $signed({3'b000, cur_start}) + 19'sd1;
  assign merge   = (idx != '0) && (t_gk == cur_gk)
                   && (gap <= $signed({12'd0, max_gap}))
                   && (span <= $signed({12'd0, max_block}));
  assign g_w     = merge ? g : ((idx == '0) ? '0 : g + 1'b1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rrc_pkg::ST_LOAD: if (in_acc && in_data.final_tag) state_next = rrc_pkg::ST_RI;
      rrc_pkg::ST_RI:   state_next = rrc_pkg::ST_RW;
      rrc_pkg::ST_RW:   state_next = rrc_pkg::ST_RJ;
      rrc_pkg::ST_RJ:   if (jd == nm1) state_next = rrc_pkg::ST_WR;
      rrc_pkg::ST_WR:   state_next = (idx == nm1) ? rrc_pkg::ST_MR : rrc_pkg::ST_RI;
      rrc_pkg::ST_MR:   state_next = rrc_pkg::ST_MC;
      rrc_pkg::ST_MC:   state_next = last_all ? rrc_pkg::ST_ER : rrc_pkg::ST_MR;
      rrc_pkg::ST_ER:   state_next = rrc_pkg::ST_EG;
      rrc_pkg::ST_EG:   state_next = rrc_pkg::ST_EO;
      rrc_pkg::ST_EO:   if (out_load) begin
        state_next = last_all ? rrc_pkg::ST_LOAD : rrc_pkg::ST_ER;
      end
      default:          state_next = rrc_pkg::ST_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = (state == rrc_pkg::ST_LOAD);
    unique case (state)
      rrc_pkg::ST_RI: key_raddr = idx;
      rrc_pkg::ST_RW: key_raddr = '0;
      default:        key_raddr = jd + 1'b1;
    endcase
  end

  // tag memory: written while loading, read by the rank count
  always_ff @(posedge clk) begin
    if (load_wr) begin
      key_mem[fill_count[rrc_pkg::IdxW-1:0]] <= {in_data.reg_kind,
        in_data.poll_interval, in_data.start_address};
      pay_mem[fill_count[rrc_pkg::IdxW-1:0]] <= {in_data.reg_count, in_data.tag_ident};
    end
    key_rd <= key_mem[key_raddr];
    pay_rd <= pay_mem[key_raddr];
  end

  // sorted memory: written at the rank, read in walk order
  always_ff @(posedge clk) begin
    if (state == rrc_pkg::ST_WR) begin
      skey_mem[rank] <= ki;
      spay_mem[rank] <= pi;
    end
    skey_rd <= skey_mem[idx];
    spay_rd <= spay_mem[idx];
  end

  // block index per tag, read at this tag and the next
  always_ff @(posedge clk) begin
    if (state == rrc_pkg::ST_MC) gidx_mem[idx] <= g_w;
    gidx_rd_a <= gidx_mem[idx];
    gidx_rd_b <= gidx_mem[idx + 1'b1];
  end

  // block start and length
  always_ff @(posedge clk) begin
    if (state == rrc_pkg::ST_MC) begin
      glen_mem[g_w] <= merge ? span[6:0] : t_cnt;
      if (!merge) gst_mem[g_w] <= t_addr;
    end
    gst_rd  <= gst_mem[gidx_rd_a];
    glen_rd <= glen_mem[gidx_rd_a];
  end

  // control and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rrc_pkg::ST_LOAD;
      fill_count <= '0;
      out_valid  <= 1'b0;
      max_gap    <= rrc_pkg::MaxGapReset;
      max_block  <= rrc_pkg::MaxBlockReset;
      idx        <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        if (cfg_index == rrc_pkg::CfgMaxGap) max_gap <= cfg_data;
        else                                 max_block <= cfg_data;
      end
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      unique case (state)
        rrc_pkg::ST_LOAD: begin
          if (load_wr) fill_count <= fill_count + 1'b1;
          if (in_acc && in_data.final_tag) begin
            n    <= load_wr ? fill_count + 1'b1 : fill_count;
            idx  <= '0;
            rank <= '0;
          end
        end
        rrc_pkg::ST_RW: begin
          ki <= key_rd;
          pi <= pay_rd;
          jd <= '0;
        end
        rrc_pkg::ST_RJ: begin
          if (key_before) rank <= rank + 1'b1;
          jd <= jd + 1'b1;
        end
        rrc_pkg::ST_WR: begin
          rank <= '0;
          idx  <= (idx == nm1) ? '0 : idx + 1'b1;
        end
        rrc_pkg::ST_MC: begin
          g      <= g_w;
          cur_gk <= t_gk;
          if (merge) begin
            cur_end <= new_end;
          end else begin
            cur_end   <= t_end;
            cur_start <= t_addr;
          end
          idx <= last_all ? '0 : idx + 1'b1;
        end
        rrc_pkg::ST_EG: blk_last <= last_all || (gidx_rd_b != gidx_rd_a);
        rrc_pkg::ST_EO: begin
          if (out_load) begin
            idx <= idx + 1'b1;
            if (last_all) fill_count <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.block_kind     <= skey_rd[41:40];
      out_data.block_start    <= gst_rd;
      out_data.block_length   <= glen_rd;
      out_data.block_interval <= skey_rd[39:16];
      out_data.member_ident   <= spay_rd[15:0];
      out_data.block_last     <= blk_last;
      out_data.plan_last      <= last_all;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= rrc_pkg::CntW'(rrc_pkg::MaxTags))
    else $error("fill count beyond store depth");
  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    (state == rrc_pkg::ST_WR) |-> (rank <= nm1))
    else $error("rank beyond tag count");
  a_plan_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.final_tag) |=> (state == rrc_pkg::ST_RI))
    else $error("final tag did not start planning");
  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (out_load && last_all) |=> (fill_count == '0))
    else $error("store not emptied after plan");
`endif

endmodule

@@ bench/register_read_coalescer_core_chk.sv @@
// ----------------------------------------------------------------------------
// register_read_coalescer_core_chk
// Watches the request, result and configuration channels, plans the read
// blocks of each tag set itself and compares every result field by field.
// ----------------------------------------------------------------------------
module register_read_coalescer_core_chk (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  rrc_pkg::tag_t    in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  rrc_pkg::result_t out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [6:0]       cfg_data,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  rrc_pkg::tag_t    tag_set[$];
  rrc_pkg::result_t plan_q[$];
  logic [6:0] gap_lim, span_lim;

  // stable insertion sort on kind, interval, address, then block walk
  task automatic plan_blocks();
    rrc_pkg::tag_t  t[$];
    rrc_pkg::tag_t  k;
    int    grp[$];
    int    g_start[$];
    int    g_len[$];
    int    j, n, g, cur_end, tag_end, new_end, gap, span;
    logic  merged;
    rrc_pkg::result_t r;
    t = tag_set;
    n = t.size();
    for (int i = 1; i < n; i++) begin
      k = t[i];
      j = i;
      while (j > 0 && {t[j-1].reg_kind, t[j-1].poll_interval, t[j-1].start_address} >
                      {k.reg_kind, k.poll_interval, k.start_address}) begin
        t[j] = t[j-1];
        j--;
      end
      t[j] = k;
    end
    g = 0;
    cur_end = 0;
    for (int i = 0; i < n; i++) begin
      tag_end = int'(t[i].start_address) + int'(t[i].reg_count) - 1;
      merged = 0;
      if (i > 0 && t[i].reg_kind == t[i-1].reg_kind &&
          t[i].poll_interval == t[i-1].poll_interval) begin
        new_end = (tag_end > cur_end) ? tag_end : cur_end;
        gap = int'(t[i].start_address) - cur_end - 1;
        span = new_end - g_start[g] + 1;
        if (gap <= int'(gap_lim) && span <= int'(span_lim)) begin
          g_len[g] = span;
          cur_end = new_end;
          merged = 1;
        end
      end
      if (!merged) begin
        if (i > 0) g++;
        g_start.push_back(t[i].start_address);
        g_len.push_back(t[i].reg_count);
        cur_end = tag_end;
      end
      grp.push_back(g);
    end
    for (int i = 0; i < n; i++) begin
      r.block_kind     = t[i].reg_kind;
      r.block_start    = g_start[grp[i]][15:0];
      r.block_length   = g_len[grp[i]][6:0];
      r.block_interval = t[i].poll_interval;
      r.member_ident   = t[i].tag_ident;
      r.plan_last      = (i == n - 1);
      r.block_last     = r.plan_last || grp[i+1] != grp[i];
      plan_q.push_back(r);
    end
    tag_set.delete();
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = plan_q.size();

  always @(posedge clk) begin
    rrc_pkg::result_t w;
    if (rst) begin
      gap_lim  <= rrc_pkg::MaxGapReset;
      span_lim <= rrc_pkg::MaxBlockReset;
      tag_set.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rrc_pkg::CfgMaxGap) gap_lim <= cfg_data;
        else span_lim <= cfg_data;
      end
      if (out_valid && out_ready) begin
        if (plan_q.size() == 0) begin
          report("unexpected result", out_data.member_ident, 0);
        end else begin
          w = plan_q.pop_front();
          if (out_data.block_kind != w.block_kind)
            report("block_kind", out_data.block_kind, w.block_kind);
          if (out_data.block_start != w.block_start)
            report("block_start", out_data.block_start, w.block_start);
          if (out_data.block_length != w.block_length)
            report("block_length", out_data.block_length, w.block_length);
          if (out_data.block_interval != w.block_interval)
            report("block_interval", out_data.block_interval, w.block_interval);
          if (out_data.member_ident != w.member_ident)
            report("member_ident", out_data.member_ident, w.member_ident);
          if (out_data.block_last != w.block_last)
            report("block_last", out_data.block_last, w.block_last);
          if (out_data.plan_last != w.plan_last)
            report("plan_last", out_data.plan_last, w.plan_last);
        end
      end
      if (in_valid && in_ready) begin
        if (tag_set.size() < rrc_pkg::MaxTags) tag_set.push_back(in_data);
        if (in_data.final_tag) plan_blocks();
      end
    end
  end
endmodule

@@ bench/register_read_coalescer_core_tb.sv @@
// ----------------------------------------------------------------------------
// register_read_coalescer_core_tb
// Drives tag sets and register settings into the coalescer, with random
// idling on both channels; the checker predicts and compares the results.
// ----------------------------------------------------------------------------
module register_read_coalescer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 200000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic cfg_valid = 0, cfg_ready, cfg_index = 0;
  logic [6:0] cfg_data = '0;
  rrc_pkg::tag_t in_data = '0;
  rrc_pkg::result_t out_data;
  int fail_count, pending;
  int idle_cycles = 0;
  bit calm = 0;   // no idling in the last part of the run
  int sent = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  register_read_coalescer_core u_top (.*);

  register_read_coalescer_core_chk u_chk (.*);

  // result side: random stall bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 18);
        repeat (n) @(negedge clk);
      end
      out_ready <= 1;
    end
  end

  // watchdog: cycles with nothing accepted
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("register_read_coalescer_core_tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [6:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // one request, held until taken; a gap burst may follow
  task automatic send_tag(rrc_pkg::tag_t t);
    int n;
    in_valid <= 1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      n = $urandom_range(1, 18);
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic rrc_pkg::tag_t rand_tag(int kinds, int ivls, int base, logic fin);
    rrc_pkg::tag_t t;
    t.reg_kind      = 2'($urandom_range(0, kinds));
    t.poll_interval = (ivls < 0) ? 24'($urandom) : 24'($urandom_range(0, ivls) * 500);
    t.start_address = (base < 0) ? 16'($urandom) : 16'(base + $urandom_range(0, 200));
    t.reg_count     = ($urandom_range(0, 15) == 0) ? 7'($urandom) : 7'($urandom_range(1, 20));
    t.tag_ident     = 16'($urandom);
    t.final_tag     = fin;
    return t;
  endfunction

  // a set of n tags; unless wild, clustered so that many of them merge
  task automatic send_set(int n, bit wild);
    int base;
    base = $urandom_range(0, 65335);
    for (int i = 0; i < n; i++)
      send_tag(rand_tag(wild ? 3 : 1, wild ? -1 : 1, wild ? -1 : base, i == n - 1));
  endtask

  initial begin
    rrc_pkg::tag_t t;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes, overlap, top of the map, zero count, single tag
    send_tag('{2'd3, 24'hFFFFFF, 16'hFFFF, 7'd125, 16'hFFFF, 1'b0});
    send_tag('{2'd3, 24'hFFFFFF, 16'hFFF0, 7'd127, 16'h0001, 1'b0});
    send_tag('{2'd0, 24'd0, 16'd0, 7'd0, 16'd0, 1'b0});
    send_tag('{2'd0, 24'd0, 16'd2, 7'd10, 16'd2, 1'b0});
    send_tag('{2'd0, 24'd0, 16'd4, 7'd2, 16'd3, 1'b0});   // inside the open block
    send_tag('{2'd0, 24'd0, 16'd17, 7'd3, 16'd4, 1'b0});  // gap of exactly 5
    send_tag('{2'd0, 24'd0, 16'd26, 7'd3, 16'd5, 1'b0});  // gap past limit
    send_tag('{2'd1, 24'd0, 16'd26, 7'd3, 16'd6, 1'b0});
    send_tag('{2'd2, 24'd1000, 16'd100, 7'd120, 16'd7, 1'b0});
    send_tag('{2'd2, 24'd1000, 16'd221, 7'd10, 16'd8, 1'b1}); // span too long
    drain();
    send_tag('{2'd1, 24'd5, 16'd9, 7'd1, 16'hABCD, 1'b1});
    drain();

    // overfull set: tags past the store limit are dropped
    for (int i = 0; i < 66; i++) begin
      t = rand_tag(1, 1, 3000, i == 65);
      send_tag(t);
    end
    drain();

    write_reg(rrc_pkg::CfgMaxBlock, 7'd0);
    write_reg(rrc_pkg::CfgMaxGap, 7'd127);
    send_set(8, 0);
    drain();
    write_reg(rrc_pkg::CfgMaxGap, 7'd0);
    write_reg(rrc_pkg::CfgMaxBlock, 7'd127);
    send_set(12, 0);
    drain();
    write_reg(rrc_pkg::CfgMaxGap, 7'd125);
    write_reg(rrc_pkg::CfgMaxBlock, 7'd1);
    send_set(6, 0);
    drain();

    // random settings and sets
    while (sent < 130) begin
      if (sent > 112) calm = 1;
      write_reg(rrc_pkg::CfgMaxGap, 7'($urandom));
      write_reg(rrc_pkg::CfgMaxBlock, 7'($urandom_range(0, 127)));
      send_set($urandom_range(1, 14), $urandom_range(0, 5) == 0);
      drain();
    end

    if (fail_count == 0)
      $display("register_read_coalescer_core_tb OK");
    else
      $display("register_read_coalescer_core_tb NOT OK");
    $finish;
  end
endmodule
